>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

>>> rtl/core/iiee_pkg.sv
// ---------------------------------------------------------------------------
// iiee_pkg
// Types and constants of the infix expression evaluator.
// ---------------------------------------------------------------------------
package iiee_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int DATA_WIDTH_DEF  = 32;

  localparam logic [2:0] TOK_NUM   = 3'd0;
  localparam logic [2:0] TOK_OP    = 3'd1;
  localparam logic [2:0] TOK_OPEN  = 3'd2;
  localparam logic [2:0] TOK_CLOSE = 3'd3;
  localparam logic [2:0] TOK_END   = 3'd4;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_POW  = 3'd4;
  localparam logic [2:0] OP_OPEN = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DIV0  = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;
  localparam logic [1:0] ST_MALF  = 2'd3;

  typedef struct packed {
    logic [2:0]         func;
    logic [2:0]         op_code;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
  } out_item_t;

  function automatic logic [1:0] prec(input logic [2:0] op);
    if (op <= OP_SUB) return 2'd1;
    if (op <= OP_DIV) return 2'd2;
    return 2'd3;
  endfunction

endpackage

>>> rtl/core/iiee_ram.sv
// ---------------------------------------------------------------------------
// iiee_ram
// Generic single-port-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module iiee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/infix_integer_expression_evaluator_unit.sv
// ---------------------------------------------------------------------------
// infix_integer_expression_evaluator_unit
// Two-stack infix evaluator over pre-split tokens, one shared ALU step a cycle.
// ---------------------------------------------------------------------------
// channel  | direction | handshake
// token    | in        | start & !busy, fields on in_item
// result   | out       | done strobe, one cycle, fields on out_item
// Number and open tokens end in dispatch; operator, close and end tokens go on
// to read the operator stack top, and end tokens then read out the result.
// Each applied operator reads its operands, executes, writes back; divide is
// bit-serial and multiply and power (square-multiply) share one multiplier.
// done strobes in the first cycle with busy low. Synchronous reset clears the
// counts; the stores need no clearing. The receiver cannot stall results.
`include "assert_macros.svh"
module infix_integer_expression_evaluator_unit #(
  parameter int STACK_DEPTH = iiee_pkg::STACK_DEPTH_DEF,
  parameter int DATA_WIDTH  = iiee_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  iiee_pkg::in_item_t  in_item,
  output logic                busy,
  output logic                done,
  output iiee_pkg::out_item_t out_item
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int BW = $clog2(DATA_WIDTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);
  localparam logic [DATA_WIDTH-1:0] ONE = DATA_WIDTH'(1);
  localparam logic [DATA_WIDTH-1:0] ALL1 = '1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_OPRD   = 4'd2;
  localparam logic [3:0] S_OPCHK  = 4'd3;
  localparam logic [3:0] S_RDB    = 4'd4;
  localparam logic [3:0] S_RDA    = 4'd5;
  localparam logic [3:0] S_EXEC   = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_POW    = 4'd8;
  localparam logic [3:0] S_WB     = 4'd9;
  localparam logic [3:0] S_RES    = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  logic [3:0] state;
  iiee_pkg::in_item_t tok;
  logic [CW-1:0] opr_cnt, opd_cnt;
  logic [1:0] err;
  logic [2:0] op;
  logic [DATA_WIDTH-1:0] a, b, r, acc, sq, rem, quo;
  logic [BW-1:0] bitc;
  logic pow_sq;

  logic opr_we, opd_we;
  logic [AW-1:0] opr_wa, opr_ra, opd_wa, opd_ra;
  logic [2:0] opr_wd, opr_rd;
  logic [DATA_WIDTH-1:0] opd_wd, opd_rd;

  iiee_ram #(.WIDTH(3), .DEPTH(STACK_DEPTH)) u_opr (
    .clk, .we(opr_we), .waddr(opr_wa), .wdata(opr_wd), .raddr(opr_ra), .rdata(opr_rd));
  iiee_ram #(.WIDTH(DATA_WIDTH), .DEPTH(STACK_DEPTH)) u_opd (
    .clk, .we(opd_we), .waddr(opd_wa), .wdata(opd_wd), .raddr(opd_ra), .rdata(opd_rd));

  logic [CW-1:0] opr_top, opd_b, opd_a;
  assign opr_top = opr_cnt - CW'(1);
  assign opd_b   = opd_cnt - CW'(1);
  assign opd_a   = opd_cnt - CW'(2);
  assign opr_ra  = opr_top[AW-1:0];
  assign opd_ra  = (state == S_RDB || state == S_OPCHK || state == S_RES) ?
                   opd_b[AW-1:0] : opd_a[AW-1:0];

  logic [DATA_WIDTH-1:0] mag_b, rem_sh, mul_x, mul_y, mul_p;
  logic [DATA_WIDTH:0] rem_sub;
  assign mag_b = b[DATA_WIDTH-1] ? (~b + ONE) : b;
  assign rem_sh = {rem[DATA_WIDTH-2:0], quo[DATA_WIDTH-1]};
  assign rem_sub = {1'b0, rem_sh} - {1'b0, mag_b};
  // the one shared multiplier: a*b, acc*sq or sq*sq
  always_comb begin
    mul_x = a;
    mul_y = b;
    if (state == S_POW && op != iiee_pkg::OP_MUL) begin
      mul_x = pow_sq ? sq : acc;
      mul_y = sq;
    end
  end
  assign mul_p = mul_x * mul_y;

  logic ext_end;
  assign busy = (state != S_IDLE);
  logic [DATA_WIDTH-1:0] val_ext;
  assign val_ext = DATA_WIDTH'(signed'(tok.value));

  always_ff @(posedge clk) begin
    opr_we <= 1'b0;
    opd_we <= 1'b0;
    done   <= 1'b0;
    if (rst) begin
      state   <= S_IDLE;
      opr_cnt <= '0;
      opd_cnt <= '0;
      err     <= iiee_pkg::ST_OK;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            tok   <= in_item;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          state <= S_IDLE;
          if (tok.func == iiee_pkg::TOK_END) begin
            state <= S_OPRD;
          end else if (err == iiee_pkg::ST_OK) begin
            unique case (tok.func)
              iiee_pkg::TOK_NUM: begin
                if (opd_cnt >= FULL) err <= iiee_pkg::ST_OVF;
                else begin
                  opd_we  <= 1'b1;
                  opd_wa  <= opd_cnt[AW-1:0];
                  opd_wd  <= val_ext;
                  opd_cnt <= opd_cnt + CW'(1);
                end
              end
              iiee_pkg::TOK_OP: begin
                if (tok.op_code > iiee_pkg::OP_POW) err <= iiee_pkg::ST_MALF;
                else state <= S_OPRD;
              end
              iiee_pkg::TOK_OPEN: begin
                if (opr_cnt >= FULL) err <= iiee_pkg::ST_OVF;
                else begin
                  opr_we  <= 1'b1;
                  opr_wa  <= opr_cnt[AW-1:0];
                  opr_wd  <= iiee_pkg::OP_OPEN;
                  opr_cnt <= opr_cnt + CW'(1);
                end
              end
              iiee_pkg::TOK_CLOSE: state <= S_OPRD;
              default: err <= iiee_pkg::ST_MALF;
            endcase
          end
        end
        S_OPRD: state <= S_OPCHK;
        S_OPCHK: begin
          // top of operator stack is in opr_rd; decide: apply, pop, push or finish
          state <= S_IDLE;
          if (tok.func == iiee_pkg::TOK_END) begin
            if (err != iiee_pkg::ST_OK) state <= S_RES;
            else if (opr_cnt == '0) begin
              if (opd_cnt != CW'(1)) err <= iiee_pkg::ST_MALF;
              state <= S_RES;
            end else if (opr_rd == iiee_pkg::OP_OPEN) begin
              err <= iiee_pkg::ST_MALF;
              state <= S_RES;
            end else state <= S_RDB;
          end else if (err != iiee_pkg::ST_OK) begin
            state <= S_IDLE;
          end else if (tok.func == iiee_pkg::TOK_CLOSE) begin
            if (opr_cnt == '0) err <= iiee_pkg::ST_MALF;
            else if (opr_rd == iiee_pkg::OP_OPEN) opr_cnt <= opr_top;
            else state <= S_RDB;
          end else begin
            if (opr_cnt != '0 && opr_rd != iiee_pkg::OP_OPEN &&
                iiee_pkg::prec(opr_rd) >= iiee_pkg::prec(tok.op_code)) begin
              state <= S_RDB;
            end else if (opr_cnt >= FULL) err <= iiee_pkg::ST_OVF;
            else begin
              opr_we  <= 1'b1;
              opr_wa  <= opr_cnt[AW-1:0];
              opr_wd  <= tok.op_code;
              opr_cnt <= opr_cnt + CW'(1);
            end
          end
          if (state == S_OPCHK) op <= opr_rd;
        end
        S_RDB: begin
          opr_cnt <= opr_top;
          if (opd_cnt < CW'(2)) begin
            err   <= iiee_pkg::ST_MALF;
            state <= (tok.func == iiee_pkg::TOK_END) ? S_RES : S_IDLE;
          end else state <= S_RDA;
        end
        S_RDA: begin
          b     <= opd_rd;
          state <= S_EXEC;
        end
        S_EXEC: begin
          a     <= opd_rd;
          state <= S_WB;
          unique case (op)
            iiee_pkg::OP_ADD: r <= opd_rd + b;
            iiee_pkg::OP_SUB: r <= opd_rd - b;
            iiee_pkg::OP_MUL: state <= S_POW;
            iiee_pkg::OP_DIV: begin
              if (b == '0) begin
                err <= iiee_pkg::ST_DIV0;
                opd_cnt <= opd_a;
                state <= (tok.func == iiee_pkg::TOK_END) ? S_RES : S_IDLE;
              end else begin
                rem   <= '0;
                quo   <= opd_rd[DATA_WIDTH-1] ? (~opd_rd + ONE) : opd_rd;
                bitc  <= BW'(DATA_WIDTH);
                state <= S_DIV;
              end
            end
            default: begin
              if (b[DATA_WIDTH-1]) begin
                if (opd_rd == ONE) r <= ONE;
                else if (opd_rd == ALL1) r <= b[0] ? ALL1 : ONE;
                else r <= '0;
              end else begin
                acc    <= ONE;
                sq     <= opd_rd;
                pow_sq <= 1'b0;
                state  <= S_POW;
              end
            end
          endcase
        end
        S_DIV: begin
          if (bitc == '0) begin
            r     <= (a[DATA_WIDTH-1] != b[DATA_WIDTH-1]) ? (~quo + ONE) : quo;
            state <= S_WB;
          end else begin
            if (!rem_sub[DATA_WIDTH]) rem <= rem_sub[DATA_WIDTH-1:0];
            else rem <= rem_sh;
            quo  <= {quo[DATA_WIDTH-2:0], ~rem_sub[DATA_WIDTH]};
            bitc <= bitc - BW'(1);
          end
        end
        S_POW: begin
          if (op == iiee_pkg::OP_MUL) begin
            r     <= mul_p;
            state <= S_WB;
          end else if (b == '0) begin
            r     <= acc;
            state <= S_WB;
          end else if (!pow_sq) begin
            if (b[0]) acc <= mul_p;
            pow_sq <= 1'b1;
          end else begin
            sq     <= mul_p;
            b      <= b >> 1;
            pow_sq <= 1'b0;
          end
        end
        S_WB: begin
          opd_we  <= 1'b1;
          opd_wa  <= opd_a[AW-1:0];
          opd_wd  <= r;
          opd_cnt <= opd_b;
          state   <= S_OPRD;
        end
        S_RES: state <= S_FIN;
        S_FIN: begin
          done <= 1'b1;
          out_item.status <= err;
          out_item.result_value <= (err == iiee_pkg::ST_OK) ?
              32'(signed'(opd_rd)) : 32'sd0;
          opr_cnt <= '0;
          opd_cnt <= '0;
          err     <= iiee_pkg::ST_OK;
          state   <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign ext_end = (state == S_FIN);

  `ASSERT_IMPLIES(a_cnt_opd, clk, rst, 1'b1, opd_cnt <= FULL)
  `ASSERT_IMPLIES(a_cnt_opr, clk, rst, 1'b1, opr_cnt <= FULL)
  `ASSERT_NEXT(a_done_fin, clk, rst, ext_end, done && !busy)
  `ASSERT_NEXT(a_clear, clk, rst, ext_end, opd_cnt == '0 && err == iiee_pkg::ST_OK)

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Infix expression evaluator testbench
// Drives token items through a start/busy handshake, predicts each end-token
// result with a two-stack evaluator of its own and checks every done strobe.
// ---------------------------------------------------------------------------
module testbench;

  localparam int DEPTH = iiee_pkg::STACK_DEPTH_DEF;
  localparam logic [31:0] MINV = 32'h8000_0000;
  localparam logic [2:0] MARK_OPEN = iiee_pkg::OP_OPEN;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  iiee_pkg::in_item_t in_item = '0;
  logic busy;
  logic done;
  iiee_pkg::out_item_t out_item;

  infix_integer_expression_evaluator_unit dut (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item),
    .busy(busy), .done(done), .out_item(out_item)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [2:0]  opr_stk [DEPTH];
  logic [31:0] val_stk [DEPTH];
  int unsigned opr_cnt, val_cnt;
  logic [1:0]  err;

  iiee_pkg::in_item_t  token_q[$];
  iiee_pkg::out_item_t expected_q[$];
  int unsigned n_fail = 0;
  longint unsigned cycles = 0;
  bit all_sent = 0;
  bit drain_hold = 0;
  int unsigned gap = 0;

  function automatic void add_token(iiee_pkg::in_item_t t);
    token_q.insert(token_q.size(), t);
  endfunction

  function automatic void raise(logic [1:0] c);
    if (err == iiee_pkg::ST_OK) err = c;
  endfunction

  function automatic int prio(logic [2:0] o);
    if (o <= iiee_pkg::OP_SUB) return 1;
    if (o <= iiee_pkg::OP_DIV) return 2;
    return 3;
  endfunction

  function automatic logic [31:0] int_power(logic [31:0] b, logic [31:0] e);
    logic [31:0] acc, sq;
    acc = 32'd1;
    sq = b;
    if (e[31]) begin
      if (b == 32'd1) return 32'd1;
      if (b == 32'hFFFF_FFFF) return e[0] ? 32'hFFFF_FFFF : 32'd1;
      return 32'd0;
    end
    while (e != 0) begin
      if (e[0]) acc = acc * sq;
      sq = sq * sq;
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic void apply_top();
    logic [2:0]  o;
    logic [31:0] a, b, r, ma, mb;
    opr_cnt--;
    o = opr_stk[opr_cnt];
    if (val_cnt < 2) begin
      raise(iiee_pkg::ST_MALF);
      return;
    end
    b = val_stk[val_cnt-1];
    a = val_stk[val_cnt-2];
    val_cnt -= 2;
    case (o)
      iiee_pkg::OP_ADD: r = a + b;
      iiee_pkg::OP_SUB: r = a - b;
      iiee_pkg::OP_MUL: r = a * b;
      iiee_pkg::OP_DIV: begin
        if (b == 0) begin
          raise(iiee_pkg::ST_DIV0);
          return;
        end
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        r = ma / mb;
        if (a[31] != b[31]) r = -r;
      end
      default: r = int_power(a, b);
    endcase
    val_stk[val_cnt++] = r;
  endfunction

  function automatic void push_opr(logic [2:0] c);
    if (opr_cnt >= DEPTH) raise(iiee_pkg::ST_OVF);
    else opr_stk[opr_cnt++] = c;
  endfunction

  function automatic void evaluate_token(iiee_pkg::in_item_t t);
    iiee_pkg::out_item_t r;
    if (t.func == iiee_pkg::TOK_END) begin
      while (err == iiee_pkg::ST_OK && opr_cnt > 0) begin
        if (opr_stk[opr_cnt-1] == MARK_OPEN) begin
          raise(iiee_pkg::ST_MALF);
          break;
        end
        apply_top();
      end
      if (err == iiee_pkg::ST_OK && val_cnt != 1) raise(iiee_pkg::ST_MALF);
      r.result_value = (err == iiee_pkg::ST_OK) ? val_stk[0] : '0;
      r.status = err;
      expected_q.insert(expected_q.size(), r);
      opr_cnt = 0;
      val_cnt = 0;
      err = iiee_pkg::ST_OK;
      return;
    end
    if (err != iiee_pkg::ST_OK) return;
    case (t.func)
      iiee_pkg::TOK_NUM: begin
        if (val_cnt >= DEPTH) raise(iiee_pkg::ST_OVF);
        else val_stk[val_cnt++] = t.value;
      end
      iiee_pkg::TOK_OP: begin
        if (t.op_code > iiee_pkg::OP_POW) begin
          raise(iiee_pkg::ST_MALF);
        end else begin
          while (err == iiee_pkg::ST_OK && opr_cnt > 0 &&
                 opr_stk[opr_cnt-1] != MARK_OPEN &&
                 prio(opr_stk[opr_cnt-1]) >= prio(t.op_code))
            apply_top();
          if (err == iiee_pkg::ST_OK) push_opr(t.op_code);
        end
      end
      iiee_pkg::TOK_OPEN: push_opr(MARK_OPEN);
      iiee_pkg::TOK_CLOSE: begin
        while (err == iiee_pkg::ST_OK) begin
          if (opr_cnt == 0) begin
            raise(iiee_pkg::ST_MALF);
            break;
          end
          if (opr_stk[opr_cnt-1] == MARK_OPEN) begin
            opr_cnt--;
            break;
          end
          apply_top();
        end
      end
      default: raise(iiee_pkg::ST_MALF);
    endcase
  endfunction

  function automatic iiee_pkg::in_item_t tok(int unsigned f, int unsigned o,
                                             logic [31:0] v);
    iiee_pkg::in_item_t t;
    t.func = 3'(f);
    t.op_code = 3'(o);
    t.value = v;
    return t;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return MINV;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(0, 3);
      default: return $urandom_range(0, 40) - 20;
    endcase
  endfunction

  // well-formed expression, optionally broken
  task automatic queue_expression(bit broken);
    int n, nest;
    n = $urandom_range(1, 7);
    nest = 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0 && nest < 4) begin
        add_token(tok(iiee_pkg::TOK_OPEN, $urandom, $urandom));
        nest++;
      end
      add_token(tok(iiee_pkg::TOK_NUM, $urandom, rand_operand()));
      if (nest > 0 && $urandom_range(0, 2) == 0) begin
        add_token(tok(iiee_pkg::TOK_CLOSE, $urandom, $urandom));
        nest--;
      end
      if (i != n-1) add_token(tok(iiee_pkg::TOK_OP, $urandom_range(0, 4), $urandom));
    end
    while (nest > 0) begin
      add_token(tok(iiee_pkg::TOK_CLOSE, $urandom, $urandom));
      nest--;
    end
    if (broken) begin
      repeat ($urandom_range(1, 3))
        add_token(tok($urandom_range(0, 7), $urandom, $urandom));
    end
    add_token(tok(iiee_pkg::TOK_END, $urandom, $urandom));
  endtask

  task automatic queue_list(iiee_pkg::in_item_t l[]);
    foreach (l[i]) add_token(l[i]);
  endtask

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        evaluate_token(in_item);
        void'(token_q.pop_front());
      end
      if (start && !busy || !start) begin
        if (gap > 0) begin
          gap <= gap - 1;
          start <= 1'b0;
        end else if (drain_hold && expected_q.size() != 0) begin
          start <= 1'b0;
        end else if (token_q.size() != 0 && !(start && !busy && token_q.size() == 0)) begin
          if (token_q.size() > 300 && $urandom_range(0, 15) == 0) begin
            gap <= $urandom_range(1, 12);
            start <= 1'b0;
          end else begin
            start <= 1'b1;
            in_item <= token_q[0];
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $error("result with no expectation: value %0d status %0d",
               out_item.result_value, out_item.status);
        n_fail++;
      end else begin
        if (out_item.result_value !== expected_q[0].result_value) begin
          $error("result_value expected %0d actual %0d",
                 expected_q[0].result_value, out_item.result_value);
          n_fail++;
        end
        if (out_item.status !== expected_q[0].status) begin
          $error("status expected %0d actual %0d", expected_q[0].status, out_item.status);
          n_fail++;
        end
        void'(expected_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 2_000_000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int cnt;
    opr_cnt = 0;
    val_cnt = 0;
    err = iiee_pkg::ST_OK;
    // directed
    queue_list('{tok(iiee_pkg::TOK_NUM, 0, 32'h7FFF_FFFF),
                 tok(iiee_pkg::TOK_OP, iiee_pkg::OP_ADD, 0),
                 tok(iiee_pkg::TOK_NUM, 0, 1), tok(iiee_pkg::TOK_END, 0, 0)});
    queue_list('{tok(iiee_pkg::TOK_NUM, 7, MINV), tok(iiee_pkg::TOK_OP, iiee_pkg::OP_DIV, 0),
                 tok(iiee_pkg::TOK_NUM, 0, -1), tok(iiee_pkg::TOK_END, 7, 32'hFFFF_FFFF)});
    queue_list('{tok(iiee_pkg::TOK_NUM, 0, -7), tok(iiee_pkg::TOK_OP, iiee_pkg::OP_DIV, 0),
                 tok(iiee_pkg::TOK_NUM, 0, 2), tok(iiee_pkg::TOK_OP, iiee_pkg::OP_SUB, 0),
                 tok(iiee_pkg::TOK_NUM, 0, 3), tok(iiee_pkg::TOK_END, 0, 0)});
    queue_list('{tok(iiee_pkg::TOK_NUM, 0, 5), tok(iiee_pkg::TOK_OP, iiee_pkg::OP_DIV, 0),
                 tok(iiee_pkg::TOK_NUM, 0, 0), tok(iiee_pkg::TOK_END, 0, 0)});
    queue_list('{tok(iiee_pkg::TOK_NUM, 0, 0), tok(iiee_pkg::TOK_OP, iiee_pkg::OP_POW, 0),
                 tok(iiee_pkg::TOK_NUM, 0, 0), tok(iiee_pkg::TOK_END, 0, 0)});
    queue_list('{tok(iiee_pkg::TOK_NUM, 0, -1), tok(iiee_pkg::TOK_OP, iiee_pkg::OP_POW, 0),
                 tok(iiee_pkg::TOK_NUM, 0, -3), tok(iiee_pkg::TOK_OP, iiee_pkg::OP_MUL, 0),
                 tok(iiee_pkg::TOK_OPEN, 0, 0), tok(iiee_pkg::TOK_NUM, 0, 3),
                 tok(iiee_pkg::TOK_OP, iiee_pkg::OP_POW, 0), tok(iiee_pkg::TOK_NUM, 0, -2),
                 tok(iiee_pkg::TOK_CLOSE, 0, 0), tok(iiee_pkg::TOK_END, 0, 0)});
    queue_list('{tok(iiee_pkg::TOK_END, 0, 0)});
    queue_list('{tok(iiee_pkg::TOK_CLOSE, 0, 0), tok(iiee_pkg::TOK_END, 0, 0)});
    queue_list('{tok(iiee_pkg::TOK_OPEN, 0, 0), tok(iiee_pkg::TOK_NUM, 0, 1),
                 tok(iiee_pkg::TOK_END, 0, 0)});
    queue_list('{tok(iiee_pkg::TOK_OP, iiee_pkg::OP_ADD, 0), tok(iiee_pkg::TOK_END, 0, 0)});
    queue_list('{tok(7, 7, 0), tok(iiee_pkg::TOK_END, 0, 0)});
    queue_list('{tok(iiee_pkg::TOK_NUM, 0, 2), tok(iiee_pkg::TOK_OP, 6, 0),
                 tok(iiee_pkg::TOK_END, 0, 0)});
    repeat (17) add_token(tok(iiee_pkg::TOK_NUM, 0, 32'h5555_5555));
    add_token(tok(iiee_pkg::TOK_END, 0, 0));
    repeat (17) add_token(tok(iiee_pkg::TOK_OPEN, 0, 0));
    add_token(tok(iiee_pkg::TOK_END, 0, 0));
    add_token(tok(iiee_pkg::TOK_NUM, 0, 2));
    add_token(tok(iiee_pkg::TOK_NUM, 0, 3));
    add_token(tok(iiee_pkg::TOK_END, 0, 0));
    // random
    cnt = 0;
    while (cnt < 1520) begin
      case ($urandom_range(0, 9))
        0: add_token(tok($urandom, $urandom, $urandom));
        1: queue_expression(1);
        default: queue_expression(0);
      endcase
      cnt = token_q.size();
    end
    repeat (40) queue_expression(0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait (token_q.size() < 1200);
    wait (expected_q.size() != 0);
    drain_hold <= 1'b1;
    wait (expected_q.size() == 0);
    @(posedge clk);
    drain_hold <= 1'b0;
    wait (token_q.size() == 0);
    wait (expected_q.size() == 0);
    repeat (300) @(posedge clk);
    if (n_fail == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl/core
rtl/core/iiee_pkg.sv
rtl/core/iiee_ram.sv
rtl/core/infix_integer_expression_evaluator_unit.sv
tb/sv/testbench.sv
